>>> sv/cpualu_pkg.sv
// types and operation codes shared by the alu core and the top level
package cpualu_pkg;

  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

  typedef enum logic [5:0] {
    FN_ADD8  = 6'd0,
    FN_ADC8  = 6'd1,
    FN_SUB8  = 6'd2,
    FN_SBC8  = 6'd3,
    FN_CP    = 6'd4,
    FN_AND   = 6'd5,
    FN_OR    = 6'd6,
    FN_XOR   = 6'd7,
    FN_INC8  = 6'd8,
    FN_DEC8  = 6'd9,
    FN_ADD16 = 6'd10,
    FN_ADC16 = 6'd11,
    FN_SBC16 = 6'd12,
    FN_INC16 = 6'd13,
    FN_DEC16 = 6'd14,
    FN_RL    = 6'd15,
    FN_RLA   = 6'd16,
    FN_RLC   = 6'd17,
    FN_RLCA  = 6'd18,
    FN_RR    = 6'd19,
    FN_RRA   = 6'd20,
    FN_RRC   = 6'd21,
    FN_RRCA  = 6'd22,
    FN_SLA   = 6'd23,
    FN_SRA   = 6'd24,
    FN_SRL   = 6'd25,
    FN_BIT   = 6'd26,
    FN_SET   = 6'd27,
    FN_RES   = 6'd28,
    FN_DAA   = 6'd29,
    FN_CPL   = 6'd30,
    FN_CCF   = 6'd31,
    FN_SCF   = 6'd32,
    FN_MOVE  = 6'd33
  } alu_func_t;

  localparam alu_func_t FN_LAST = FN_MOVE;

endpackage

>>> sv/cpualu_core.sv
// combinational alu datapath: result, write enable and next flags for one operation
module cpualu_core import cpualu_pkg::*; (
  input  logic [5:0]  func,
  input  logic [15:0] lhs,
  input  logic [15:0] rhs,
  input  logic [2:0]  bit_index,
  input  flags_t      flags_in,
  output logic [15:0] result,
  output logic        writes_result,
  output flags_t      flags_out
);

  function automatic logic [8:0] daa_adjust(input logic [7:0] a, input flags_t f);
    logic [7:0] add;
    logic       nc;
    begin
      add = 8'h00;
      nc  = 1'b0;
      if (f.n) begin
        if (f.c) begin
          add = f.h ? 8'h9a : 8'ha0;
          nc  = 1'b1;
        end else if (f.h) begin
          add = 8'hfa;
        end
      end else if (f.c) begin
        add = (f.h || (a[3:0] >= 4'ha)) ? 8'h66 : 8'h60;
        nc  = 1'b1;
      end else if (f.h) begin
        if (a[7:4] >= 4'ha) begin
          add = 8'h66;
          nc  = 1'b1;
        end else begin
          add = 8'h06;
        end
      end else if (a[3:0] >= 4'ha) begin
        if (a[7:4] >= 4'h9) begin
          add = 8'h66;
          nc  = 1'b1;
        end else begin
          add = 8'h06;
        end
      end else if (a[7:4] >= 4'ha) begin
        add = 8'h60;
        nc  = 1'b1;
      end
      daa_adjust = {nc, a + add};
    end
  endfunction

  logic [7:0]  a;
  logic [7:0]  v;
  logic        cin;
  logic [7:0]  bit_mask;

  assign a        = lhs[7:0];
  assign v        = rhs[7:0];
  assign cin      = flags_in.c;
  assign bit_mask = 8'b1 << bit_index;

  always_comb begin
    logic [8:0]  t9;
    logic [16:0] t17;
    logic        ci;
    logic        out_bit;
    logic        fill;
    logic [7:0]  sh;
    logic [8:0]  daa_w;
    t9      = '0;
    t17     = '0;
    ci      = 1'b0;
    out_bit = 1'b0;
    fill    = 1'b0;
    sh      = '0;
    daa_w   = '0;
    result        = lhs;
    writes_result = 1'b1;
    flags_out     = flags_in;
    unique case (func)
      FN_ADD8, FN_ADC8: begin
        ci = (func == FN_ADC8) ? cin : 1'b0;
        t9 = {1'b0, a} + {1'b0, v} + {8'b0, ci};
        flags_out.z = (t9[7:0] == 8'h00);
        flags_out.n = 1'b0;
        flags_out.h = a[4] ^ v[4] ^ t9[4];
        flags_out.c = t9[8];
        result = {8'h00, t9[7:0]};
      end
      FN_SUB8, FN_SBC8, FN_CP: begin
        ci = (func == FN_SBC8) ? cin : 1'b0;
        t9 = {1'b0, a} - {1'b0, v} - {8'b0, ci};
        flags_out.z = (t9[7:0] == 8'h00);
        flags_out.n = 1'b1;
        flags_out.h = a[4] ^ v[4] ^ t9[4];
        flags_out.c = t9[8];
        if (func == FN_CP) begin
          writes_result = 1'b0;
        end else begin
          result = {8'h00, t9[7:0]};
        end
      end
      FN_AND, FN_OR, FN_XOR: begin
        sh = (func == FN_AND) ? (a & v) : (func == FN_OR) ? (a | v) : (a ^ v);
        result = {8'h00, sh};
        flags_out.z = (sh == 8'h00);
        flags_out.n = 1'b0;
        flags_out.h = (func == FN_AND);
        flags_out.c = 1'b0;
      end
      FN_INC8, FN_DEC8: begin
        sh = (func == FN_INC8) ? (a + 8'd1) : (a - 8'd1);
        result = {8'h00, sh};
        flags_out.z = (sh == 8'h00);
        flags_out.n = (func == FN_DEC8);
        flags_out.h = (func == FN_INC8) ? (a[3:0] == 4'hf) : (a[3:0] == 4'h0);
      end
      FN_ADD16, FN_ADC16, FN_SBC16: begin
        ci = (func == FN_ADD16) ? 1'b0 : cin;
        if (func == FN_SBC16) begin
          t17 = {1'b0, lhs} - {1'b0, rhs} - {16'b0, ci};
        end else begin
          t17 = {1'b0, lhs} + {1'b0, rhs} + {16'b0, ci};
        end
        flags_out.z = (t17[15:0] == 16'h0000);
        flags_out.n = (func == FN_SBC16);
        flags_out.h = lhs[12] ^ rhs[12] ^ t17[12];
        flags_out.c = t17[16];
        result = t17[15:0];
      end
      FN_INC16: result = lhs + 16'd1;
      FN_DEC16: result = lhs - 16'd1;
      FN_RL, FN_RLA, FN_RLC, FN_RLCA, FN_SLA: begin
        out_bit = a[7];
        if (func == FN_RL || func == FN_RLA) begin
          fill = cin;
        end else if (func == FN_SLA) begin
          fill = 1'b0;
        end else begin
          fill = out_bit;
        end
        sh = {a[6:0], fill};
        result = {8'h00, sh};
        flags_out.c = out_bit;
        flags_out.n = 1'b0;
        flags_out.h = 1'b0;
        if (func != FN_RLA) flags_out.z = (sh == 8'h00);
      end
      FN_RR, FN_RRA, FN_RRC, FN_RRCA, FN_SRA, FN_SRL: begin
        out_bit = a[0];
        if (func == FN_RR || func == FN_RRA) begin
          fill = cin;
        end else if (func == FN_SRA) begin
          fill = a[7];
        end else if (func == FN_SRL) begin
          fill = 1'b0;
        end else begin
          fill = out_bit;
        end
        sh = {fill, a[7:1]};
        result = {8'h00, sh};
        flags_out.c = out_bit;
        flags_out.n = 1'b0;
        flags_out.h = 1'b0;
        if (func != FN_RRA && func != FN_RRCA) flags_out.z = (sh == 8'h00);
      end
      FN_BIT: begin
        flags_out.z = ((v & bit_mask) == 8'h00);
        flags_out.n = 1'b0;
        flags_out.h = 1'b1;
        writes_result = 1'b0;
      end
      FN_SET: result = {8'h00, a | bit_mask};
      FN_RES: result = {8'h00, a & ~bit_mask};
      FN_DAA: begin
        daa_w = daa_adjust(a, flags_in);
        result = {8'h00, daa_w[7:0]};
        flags_out.c = daa_w[8];
        flags_out.z = (daa_w[7:0] == 8'h00);
      end
      FN_CPL: begin
        result = {8'h00, ~a};
        flags_out.n = 1'b1;
        flags_out.h = 1'b1;
      end
      FN_CCF: begin
        flags_out.n = 1'b0;
        flags_out.h = cin;
        flags_out.c = ~cin;
        writes_result = 1'b0;
      end
      FN_SCF: begin
        flags_out.n = 1'b0;
        flags_out.h = 1'b0;
        flags_out.c = 1'b1;
        writes_result = 1'b0;
      end
      FN_MOVE: result = rhs;
      default: writes_result = 1'b0;
    endcase
  end

endmodule

>>> sv/cpu_alu_with_flags.sv
// top level: input register, alu core, flag register and result register
// an accepted word moves from the input register to the offered result register
// throughput: one word per cycle while out_ready is high; the flag register
//   closes the loop between consecutive operations in the single alu pass
// reset: synchronous active-low rst_n empties both stages and clears Z N H C
module cpu_alu_with_flags import cpualu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [5:0]  in_func,
  input  logic [15:0] in_lhs,
  input  logic [15:0] in_rhs,
  input  logic [2:0]  in_bit_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_result,
  output logic        out_writes_result,
  output logic        out_zero_flag,
  output logic        out_subtract_flag,
  output logic        out_half_carry_flag,
  output logic        out_carry_flag
);

  logic        s1_valid_r;
  logic [5:0]  s1_func_r;
  logic [15:0] s1_lhs_r;
  logic [15:0] s1_rhs_r;
  logic [2:0]  s1_bit_index_r;
  flags_t      flag_r;
  logic        out_valid_r;
  logic [15:0] out_result_r;
  logic        out_wr_r;
  flags_t      out_flags_r;
  logic        s1_move;
  logic [15:0] alu_result;
  logic        alu_wr;
  flags_t      flag_nxt;

  assign s1_move  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_move;

  cpualu_core u_core (
    .func          (s1_func_r),
    .lhs           (s1_lhs_r),
    .rhs           (s1_rhs_r),
    .bit_index     (s1_bit_index_r),
    .flags_in      (flag_r),
    .result        (alu_result),
    .writes_result (alu_wr),
    .flags_out     (flag_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      flag_r      <= '0;
    end else begin
      if (in_ready) s1_valid_r <= in_valid;
      if (s1_move) begin
        out_valid_r <= 1'b1;
        flag_r      <= flag_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_func_r      <= in_func;
      s1_lhs_r       <= in_lhs;
      s1_rhs_r       <= in_rhs;
      s1_bit_index_r <= in_bit_index;
    end
    if (s1_move) begin
      out_result_r <= alu_result;
      out_wr_r     <= alu_wr;
      out_flags_r  <= flag_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_result          = out_result_r;
  assign out_writes_result   = out_wr_r;
  assign out_zero_flag       = out_flags_r.z;
  assign out_subtract_flag   = out_flags_r.n;
  assign out_half_carry_flag = out_flags_r.h;
  assign out_carry_flag      = out_flags_r.c;

  a_flags_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_move |=> $stable(flag_r))
    else $error("flag register changed without an operation");

  a_flags_match: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move |=> out_flags_r == flag_r)
    else $error("reported flags differ from stored flags");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_ready |-> !in_ready)
    else $error("input accepted while both stages are full");

  a_unknown_func: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move && (s1_func_r > FN_LAST) |=>
      !out_wr_r && out_result_r == $past(s1_lhs_r) && out_flags_r == $past(flag_r))
    else $error("unknown operation changed state");

endmodule
